// ===== hw/rtl/equirect_to_cylinder_coord_map_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the equirect-to-cylinder coordinate mapper
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef EQUIRECT_TO_CYLINDER_COORD_MAP_DEFINES_SVH
`define EQUIRECT_TO_CYLINDER_COORD_MAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ECM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ecm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ECM_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ecm assertion failed");

`endif

// ===== hw/rtl/ecm_pkg.sv =====
// ----------------------------------------------------------------------------
// ecm_pkg
// Types, constants and the CORDIC arctangent table of the coordinate mapper.
// ----------------------------------------------------------------------------
package ecm_pkg;

  typedef logic signed [15:0] coord_in_t;
  typedef logic signed [23:0] coord_out_t;

  localparam int TBL_LEN = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [23:0] INVPI_Q24 = 24'sd5340354;
  localparam coord_out_t OUT_MAX = 24'sd8388607;
  localparam coord_out_t OUT_MIN = -24'sd8388608;

  localparam logic [31:0] ATAN_TBL [TBL_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Angle of step i, 2^31 = pi.
  function automatic logic signed [33:0] atan_at(input int i);
    return $signed({2'b00, ATAN_TBL[i]});
  endfunction

endpackage

// ===== hw/rtl/ecm_in_if.sv =====
// ----------------------------------------------------------------------------
// ecm_in_if
// Destination coordinate channel: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface ecm_in_if import ecm_pkg::*; ();
  logic      valid;
  logic      ready;
  coord_in_t dest_x;
  coord_in_t dest_y;

  modport source (output valid, output dest_x, output dest_y, input ready);
  modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

// ===== hw/rtl/ecm_out_if.sv =====
// ----------------------------------------------------------------------------
// ecm_out_if
// Source coordinate channel: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface ecm_out_if import ecm_pkg::*; ();
  logic       valid;
  logic       ready;
  coord_out_t source_x;
  coord_out_t source_y;
  logic       clipped;

  modport source (output valid, output source_x, output source_y, output clipped,
                  input ready);
  modport sink (input valid, input source_x, input source_y, input clipped,
                output ready);
endinterface

// ===== hw/rtl/ecm_div.sv =====
// ----------------------------------------------------------------------------
// ecm_div
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// ----------------------------------------------------------------------------
module ecm_div #(
  parameter int NW = 34,
  parameter int DW = 10,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [TW-1:0]        in_tag,
  output logic                 out_valid,
  output logic signed [NW:0]   quo,
  output logic [TW-1:0]        out_tag
);

  logic [NW:0]   v_r;
  logic          out_v_r;
  logic [NW-1:0] wq_r  [NW+1];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] dm_r  [NW];
  logic          neg_r [NW+1];
  logic [TW-1:0] tag_r [NW+1];
  logic signed [NW:0] quo_r;
  logic [TW-1:0] tag_out_r;

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;
  logic [DW:0]   trial   [NW];
  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] wq_nxt  [NW];

  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      trial[k] = {rem_r[k], wq_r[k][NW-1]};
      if (trial[k] >= {1'b0, dm_r[k]}) begin
        rem_nxt[k] = DW'(trial[k] - {1'b0, dm_r[k]});
        wq_nxt[k]  = {wq_r[k][NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][DW-1:0];
        wq_nxt[k]  = {wq_r[k][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[NW-1:0], in_valid};
      out_v_r <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wq_r[0]  <= num_mag;
      rem_r[0] <= '0;
      dm_r[0]  <= den_mag;
      neg_r[0] <= num[NW-1] ^ den[DW-1];
      tag_r[0] <= in_tag;
      for (int k = 0; k < NW; k++) begin
        wq_r[k+1]  <= wq_nxt[k];
        neg_r[k+1] <= neg_r[k];
        tag_r[k+1] <= tag_r[k];
      end
      for (int k = 0; k < NW-1; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        dm_r[k+1]  <= dm_r[k];
      end
      quo_r     <= neg_r[NW] ? -$signed({1'b0, wq_r[NW]}) : $signed({1'b0, wq_r[NW]});
      tag_out_r <= tag_r[NW];
    end
  end

  assign out_valid = out_v_r;
  assign quo       = quo_r;
  assign out_tag   = tag_out_r;

endmodule

// ===== hw/rtl/ecm_cordic.sv =====
// ----------------------------------------------------------------------------
// ecm_cordic
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, Q20 cos/sin.
// ----------------------------------------------------------------------------
module ecm_cordic import ecm_pkg::*; #(
  parameter int STEPS = 16,
  parameter int TW    = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [33:0] z,
  input  logic [TW-1:0]      in_tag,
  output logic               out_valid,
  output logic signed [23:0] cos_q20,
  output logic signed [23:0] sin_q20,
  output logic [TW-1:0]      out_tag
);

  logic [STEPS:0]     v_r;
  logic signed [33:0] x_r [STEPS+1];
  logic signed [33:0] y_r [STEPS+1];
  logic signed [33:0] z_r [STEPS];
  logic [TW-1:0]      tag_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= z;
      tag_r[0] <= in_tag;
      for (int i = 0; i < STEPS; i++) begin
        // rotate toward zero residual angle
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
        tag_r[i+1] <= tag_r[i];
      end
      for (int i = 0; i < STEPS-1; i++) begin
        z_r[i+1] <= z_r[i][33] ? z_r[i] + atan_at(i) : z_r[i] - atan_at(i);
      end
    end
  end

  assign out_valid = v_r[STEPS];
  assign cos_q20   = x_r[STEPS][33:10];
  assign sin_q20   = y_r[STEPS][33:10];
  assign out_tag   = tag_r[STEPS];

endmodule

// ===== hw/rtl/equirect_to_cylinder_coord_map.sv =====
// ----------------------------------------------------------------------------
// equirect_to_cylinder_coord_map: throughput one item per cycle while the
// output buffer is not full; when it is full the whole pipeline holds.
// A two-entry output buffer keeps accepting while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline and sets prism_sides to 0.
// ----------------------------------------------------------------------------
module equirect_to_cylinder_coord_map import ecm_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_SIDES    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  ecm_in_if.sink     in_item,
  ecm_out_if.source  out_item
);

  localparam int SW  = $clog2(MAX_SIDES + 1);
  localparam int CW  = (SW > 7) ? SW : 7;
  localparam int PW  = 16 + SW + 1;          // dest_x * sides
  localparam int NW1 = 34;                   // residual angle numerator
  localparam int DW1 = SW + 1;
  localparam int NW3 = 64;                   // frac and latitude numerators
  localparam int TW5 = PW + 22;              // face/frac sum before /sides
  localparam int T1W = 1 + SW + PW + 16;     // prism, sides, face, dest_x
  localparam int T3W = T1W + 3;
  localparam int T5W = 24 + 1 + 1 + 16;

  // Saturate to Q8.16; top bit reports clipping.
  function automatic logic [24:0] sat24(input logic signed [64:0] v);
    if (v > 65'(OUT_MAX)) return {1'b1, OUT_MAX};
    if (v < 65'(OUT_MIN)) return {1'b1, OUT_MIN};
    return {1'b0, v[23:0]};
  endfunction

  // --------------------------------------------------------------------------
  // Configuration register and global advance
  // --------------------------------------------------------------------------
  logic [6:0] prism_sides_r;
  logic [1:0] cnt_r;
  logic       en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prism_sides_r <= '0;
    end else if (cfg_we) begin
      prism_sides_r <= cfg_data;
    end
  end

  // The whole pipeline moves as one; hold it only when the output buffer is full.
  assign en            = (cnt_r != 2'd2);
  assign in_item.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: clamp sides, pick nearest face, form residual numerator and the
  // wrapped latitude angle (2^31 = pi).
  // --------------------------------------------------------------------------
  logic [SW-1:0]        s0;
  logic signed [PW-1:0] prod0, t0, face0;
  logic signed [16:0]   r0;
  logic signed [33:0]   num0;
  logic signed [15:0]   ysum0;
  logic signed [14:0]   ry0;
  logic signed [33:0]   zl0;

  assign s0    = (CW'(prism_sides_r) > CW'(MAX_SIDES)) ? SW'(MAX_SIDES) : SW'(prism_sides_r);
  assign prod0 = PW'(in_item.dest_x) * PW'($signed({1'b0, s0}));
  assign t0    = prod0 + PW'(16384);
  // floor((x*sides + half) / 32768): exact half-way points round up
  assign face0 = t0 >>> 15;
  assign r0    = $signed({2'b00, t0[14:0]}) - 17'sd16384;
  assign num0  = 34'($signed({r0, 17'b0}));
  // tangent has period pi: wrap latitude into [-1/2, 1/2)
  assign ysum0 = in_item.dest_y + 16'sd8192;
  assign ry0   = $signed({1'b0, ysum0[13:0]}) - 15'sd8192;
  assign zl0   = 34'($signed({ry0, 17'b0}));

  logic                 v1_r;
  logic                 pr1_r;
  logic [SW-1:0]        s1_r;
  logic signed [PW-1:0] face1_r;
  logic signed [33:0]   num1_r, zl1_r;
  logic signed [15:0]   dx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr1_r   <= (s0 >= SW'(3));
      s1_r    <= s0;
      face1_r <= face0;
      num1_r  <= num0;
      zl1_r   <= zl0;
      dx1_r   <= in_item.dest_x;
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: residual angle = num/sides, half-face angle = pi/sides
  // --------------------------------------------------------------------------
  logic                 v2;
  logic signed [NW1:0]  q1, q2;
  logic [T1W+33:0]      tag2;
  logic                 pr2;
  logic [SW-1:0]        s2;
  logic signed [PW-1:0] face2;
  logic signed [15:0]   dx2;
  logic signed [33:0]   zl2;

  ecm_div #(.NW(NW1), .DW(DW1), .TW(T1W + 34)) u_div_phib (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_r),
    .num(num1_r), .den($signed({1'b0, s1_r})),
    .in_tag({pr1_r, s1_r, face1_r, dx1_r, zl1_r}),
    .out_valid(v2), .quo(q1), .out_tag(tag2)
  );

  ecm_div #(.NW(NW1), .DW(DW1), .TW(1)) u_div_half (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_r),
    .num(34'sh0_8000_0000), .den($signed({1'b0, s1_r})),
    .in_tag(1'b0),
    .out_valid(), .quo(q2), .out_tag()
  );

  assign {pr2, s2, face2, dx2, zl2} = tag2;

  // --------------------------------------------------------------------------
  // Three CORDIC pipelines side by side: residual, half-face, latitude
  // --------------------------------------------------------------------------
  logic               v3;
  logic signed [23:0] cp, sp, ch, sh, cl, sl;
  logic [T1W-1:0]     tag3;
  logic               pr3;
  logic [SW-1:0]      s3;
  logic signed [PW-1:0] face3;
  logic signed [15:0] dx3;

  ecm_cordic #(.STEPS(CORDIC_STEPS), .TW(T1W)) u_cordic_phib (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2), .z(q1[33:0]),
    .in_tag({pr2, s2, face2, dx2}),
    .out_valid(v3), .cos_q20(cp), .sin_q20(sp), .out_tag(tag3)
  );

  ecm_cordic #(.STEPS(CORDIC_STEPS), .TW(1)) u_cordic_half (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2), .z(q2[33:0]),
    .in_tag(1'b0),
    .out_valid(), .cos_q20(ch), .sin_q20(sh), .out_tag()
  );

  ecm_cordic #(.STEPS(CORDIC_STEPS), .TW(1)) u_cordic_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v2), .z(zl2),
    .in_tag(1'b0),
    .out_valid(), .cos_q20(cl), .sin_q20(sl), .out_tag()
  );

  assign {pr3, s3, face3, dx3} = tag3;

  // --------------------------------------------------------------------------
  // Stage 4: face products. Cylinder mode uses a unit secant.
  // --------------------------------------------------------------------------
  logic signed [47:0] psh, pnf;
  assign psh = 48'(cp) * 48'(sh);
  assign pnf = 48'(sp) * 48'(ch);

  logic               v4_r;
  logic signed [48:0] den4_r;
  logic signed [47:0] nf4_r;
  logic signed [23:0] cphi4_r, cl4_r, sl4_r;
  logic [T1W-1:0]     tag4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den4_r  <= $signed({psh, 1'b0});
      nf4_r   <= pnf;
      cphi4_r <= pr3 ? cp : 24'sd1048576;
      cl4_r   <= cl;
      sl4_r   <= sl;
      tag4_r  <= tag3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: latitude cosine product and numerator; flag the pole cases
  // --------------------------------------------------------------------------
  logic signed [47:0] pd, pn;
  assign pd = 48'(cl4_r) * 48'(cphi4_r);
  assign pn = 48'(sl4_r) * 48'(INVPI_Q24);

  logic               v5_r;
  logic signed [63:0] fn5_r;
  logic signed [48:0] den5_r;
  logic signed [47:0] n5_r;
  logic signed [35:0] dd5_r;
  logic [T3W-1:0]     tag5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn5_r  <= $signed({nf4_r, 16'b0});
      den5_r <= den4_r;
      n5_r   <= pn;
      dd5_r  <= $signed({pd[47:20], 8'b0});
      tag5_r <= {tag4_r, (den4_r == '0), (pd[47:20] == '0), pn[47]};
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: tangent ratio across the face, and secant-scaled latitude.
  // Equal numerator width keeps both lanes in step.
  // --------------------------------------------------------------------------
  logic                 v6;
  logic signed [NW3:0]  q3, q4;
  logic [T3W-1:0]       tag6;
  logic                 pr6, denz6, dz6, nneg6;
  logic [SW-1:0]        s6;
  logic signed [PW-1:0] face6;
  logic signed [15:0]   dx6;

  ecm_div #(.NW(NW3), .DW(49), .TW(T3W)) u_div_frac (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_r),
    .num(fn5_r), .den(den5_r), .in_tag(tag5_r),
    .out_valid(v6), .quo(q3), .out_tag(tag6)
  );

  ecm_div #(.NW(NW3), .DW(36), .TW(1)) u_div_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5_r),
    .num(64'(n5_r)), .den(dd5_r), .in_tag(1'b0),
    .out_valid(), .quo(q4), .out_tag()
  );

  assign {pr6, s6, face6, dx6, denz6, dz6, nneg6} = tag6;

  // --------------------------------------------------------------------------
  // Stage 7: close source_y, form the unrolled face position
  // --------------------------------------------------------------------------
  logic signed [37:0]    frac6;
  logic signed [TW5-1:0] tn6;
  logic [24:0]           ysat6;
  logic signed [23:0]    ty6;
  logic                  cy6;

  always_comb begin
    // a huge ratio saturates source_x either way; clamp it to keep the sum narrow
    if (denz6) begin
      frac6 = '0;
    end else if (q3 > 65'sd68719476736) begin
      frac6 = 38'sd68719476736;
    end else if (q3 < -65'sd68719476736) begin
      frac6 = -38'sd68719476736;
    end else begin
      frac6 = q3[37:0];
    end
    tn6   = ((TW5'(face6) <<< 16) + TW5'(frac6)) <<< 1;
    ysat6 = sat24(q4);
    if (dz6) begin
      // tangent pole: saturate with the numerator's sign
      ty6 = nneg6 ? OUT_MIN : OUT_MAX;
      cy6 = 1'b1;
    end else begin
      ty6 = ysat6[23:0];
      cy6 = ysat6[24];
    end
  end

  logic                  v7_r;
  logic signed [TW5-1:0] tn7_r;
  logic [SW-1:0]         s7_r;
  logic [T5W-1:0]        tag7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn7_r  <= tn6;
      s7_r   <= s6;
      tag7_r <= {ty6, cy6, pr6, dx6};
    end
  end

  // --------------------------------------------------------------------------
  // Divide the face position by sides
  // --------------------------------------------------------------------------
  logic                 v8;
  logic signed [TW5:0]  q5;
  logic [T5W-1:0]       tag8;
  logic signed [23:0]   ty8;
  logic                 cy8, pr8;
  logic signed [15:0]   dx8;

  ecm_div #(.NW(TW5), .DW(DW1), .TW(T5W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v7_r),
    .num(tn7_r), .den($signed({1'b0, s7_r})), .in_tag(tag7_r),
    .out_valid(v8), .quo(q5), .out_tag(tag8)
  );

  assign {ty8, cy8, pr8, dx8} = tag8;

  // --------------------------------------------------------------------------
  // Stage 9: pick source_x by mode, merge clip flags
  // --------------------------------------------------------------------------
  logic [24:0] xsat8;
  assign xsat8 = sat24(65'(q5));

  logic               v9_r;
  logic signed [23:0] tx9_r, ty9_r;
  logic               cl9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx9_r <= pr8 ? xsat8[23:0] : (24'(dx8) <<< 2);
      ty9_r <= ty8;
      cl9_r <= cy8 | (pr8 & xsat8[24]);
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: two entries, head drives the port
  // --------------------------------------------------------------------------
  logic [48:0] buf0_r, buf1_r;
  logic        push, pop;

  assign push = en & v9_r;
  assign pop  = out_item.valid & out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) buf0_r <= {tx9_r, ty9_r, cl9_r};
        else               buf1_r <= {tx9_r, ty9_r, cl9_r};
      end
      2'b01: begin
        buf0_r <= buf1_r;
      end
      2'b11: begin
        // one entry leaves while one arrives: refill the head
        if (cnt_r == 2'd1) buf0_r <= {tx9_r, ty9_r, cl9_r};
        else begin
          buf0_r <= buf1_r;
          buf1_r <= {tx9_r, ty9_r, cl9_r};
        end
      end
      default: begin
        buf0_r <= buf0_r;
      end
    endcase
  end

  assign out_item.valid    = (cnt_r != 2'd0);
  assign out_item.source_x = buf0_r[48:25];
  assign out_item.source_y = buf0_r[24:1];
  assign out_item.clipped  = buf0_r[0];

endmodule

// ===== hw/rtl/ecm_checker.sv =====
// ----------------------------------------------------------------------------
// ecm_checker
// Port-level checks of the coordinate mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "equirect_to_cylinder_coord_map_defines.svh"

module ecm_checker import ecm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input coord_out_t source_x,
  input coord_out_t source_y,
  input logic       clipped
);

  // a pending result is not withdrawn
  `ECM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // the clip flag comes only with a saturated coordinate
  `ECM_ASSERT_IMP(a_clip_sat, clk, rst_n, out_valid && clipped, (source_y == OUT_MAX) || (source_y == OUT_MIN) || (source_x == OUT_MAX) || (source_x == OUT_MIN))

  // input back-pressure only while results wait at the output
  `ECM_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid)

endmodule

bind equirect_to_cylinder_coord_map ecm_checker u_ecm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_item.ready),
  .out_valid(out_item.valid),
  .out_ready(out_item.ready),
  .source_x(out_item.source_x),
  .source_y(out_item.source_y),
  .clipped(out_item.clipped)
);

// ===== tb/ecm_coord_checker.sv =====
// ----------------------------------------------------------------------------
// ecm_coord_checker
// Watches both channels and the sides register. Predicts every source
// coordinate in fixed point and compares each result in arrival order.
// ----------------------------------------------------------------------------
module ecm_coord_checker import ecm_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int MAX_SIDES    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  ecm_in_if          in_mon,
  ecm_out_if         out_mon,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_out_t sx;
    coord_out_t sy;
    logic       clip;
  } src_coord_t;

  src_coord_t coord_q[$];
  logic [6:0] sides_reg;

  // Rotation-mode CORDIC; angle 2^31 = pi, cos/sin floored to Q20.
  task automatic cordic_rot(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STEPS && i < TBL_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
      end
    end
    c = x >>> 10;
    s = y >>> 10;
  endtask

  function automatic longint clamp24(input longint v, inout logic clip);
    if (v > 8388607) begin
      clip = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      clip = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  // tan(pi*dy)/(pi*cphi) in Q16, latitude wrapped into [-0.5, 0.5).
  task automatic lat_scale(input longint dy, input longint cphi, inout logic clip,
                           output longint res);
    longint r, c, s, d, n;
    r = ((dy + 8192) & 16383) - 8192;
    cordic_rot(r * 131072, c, s);
    d = (c * cphi) >>> 20;
    n = s * 5340354;
    if (d == 0) begin
      clip = 1'b1;
      res = (n >= 0) ? 8388607 : -8388608;
    end else begin
      res = clamp24(n / (d * 256), clip);
    end
  endtask

  task automatic map_coord(input coord_in_t x, input coord_in_t y, input logic [6:0] cfg,
                           output src_coord_t o);
    longint dx, dy, sides, tx, ty, face, num, phib, cp, sp, ch, sh, den, frac, t;
    logic clip;
    dx = longint'(x);
    dy = longint'(y);
    sides = (cfg > MAX_SIDES) ? MAX_SIDES : cfg;
    clip = 1'b0;
    if (sides < 3) begin
      tx = clamp24(dx * 4, clip);
      lat_scale(dy, 64'sd1048576, clip, ty);
    end else begin
      // face = floor((dx*sides + 0.5*32768) / 32768)
      t = dx * sides + 16384;
      face = t / 32768;
      if (t % 32768 != 0 && t < 0) face--;
      num = dx * sides * 131072 - face * 64'sd4294967296;
      phib = num / sides;
      cordic_rot(phib, cp, sp);
      cordic_rot(64'sd2147483648 / sides, ch, sh);
      den = 2 * cp * sh;
      frac = (den != 0) ? (sp * ch * 65536) / den : 0;
      tx = clamp24(((face * 65536 + frac) * 2) / sides, clip);
      lat_scale(dy, cp, clip, ty);
    end
    o.sx = tx[23:0];
    o.sy = ty[23:0];
    o.clip = clip;
  endtask

  assign pending = coord_q.size();

  always @(posedge clk) begin
    src_coord_t e, got;
    if (!rst_n) begin
      sides_reg = '0;
      coord_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) sides_reg = cfg_data;
      if (in_mon.valid && in_mon.ready) begin
        map_coord(in_mon.dest_x, in_mon.dest_y, sides_reg, e);
        coord_q.push_back(e);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.source_x, out_mon.source_y, out_mon.clipped};
        if (coord_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected item: sx=%0d sy=%0d clip=%0b",
                                         got.sx, got.sy, got.clip);
        end else begin
          e = coord_q.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp sx=%0d sy=%0d clip=%0b got sx=%0d sy=%0d clip=%0b",
                       e.sx, e.sy, e.clip, got.sx, got.sy, got.clip);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_equirect_to_cylinder_coord_map.sv =====
// ----------------------------------------------------------------------------
// tb_equirect_to_cylinder_coord_map
// Stimulus and verdict for the coordinate mapper. Runs a series of sides
// settings (cylinder, small prisms, the clamp limit and beyond), each with a
// directed set of corner points followed by random points, while the output
// side stalls on its own pattern. The checker does all the comparing.
// ----------------------------------------------------------------------------
module tb_equirect_to_cylinder_coord_map;
  import ecm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [6:0] cfg_data;
  int         fail_count;
  int         pending;
  bit         rst_done;

  ecm_in_if  in_ch();
  ecm_out_if out_ch();

  equirect_to_cylinder_coord_map u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  ecm_coord_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (~2k items, long stalls).
  initial begin
    #5ms;
    $display("[equirect_to_cylinder_coord_map] ERROR");
    $finish;
  end

  // Receiver: switch among random stall modes; once, after 600 items have
  // gone in, hold ready low for a long stretch while the sender keeps offering, so the
  // pipeline and its output buffer fill and in_ready drops.
  initial begin
    int cyc;
    int mode;
    int acc;
    int hold_left;
    bit long_done;
    out_ch.ready <= 1'b0;
    wait (rst_done);
    cyc = 0;
    mode = 0;
    acc = 0;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (in_ch.valid && in_ch.ready) acc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (!long_done && acc >= 600) begin
        long_done = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  int burst_left;

  // Offer one item and hold it until the handshake; idle between bursts.
  task automatic send_coord(input coord_in_t x, input coord_in_t y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.dest_x <= x;
    in_ch.dest_y <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic coord_in_t rand_coord(input int kind);
    case (kind)
      0: return coord_in_t'($urandom());
      1: return coord_in_t'($urandom_range(0, 32768) - 16384);
      default: return coord_in_t'($urandom_range(0, 64) - 32 + 8192);
    endcase
  endfunction

  // Corner points: field limits, the tangent poles, face half-way points.
  localparam int N_DIR = 16;
  localparam coord_in_t DIR_X [N_DIR] = '{
    16'sd0, 16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd8192,
    -16'sd8192, 16'sd8191, 16'sd4096, -16'sd4096, 16'sd2731, 16'sd1,
    -16'sd1, 16'sd12000, 16'sd5461, -16'sd16383
  };
  localparam coord_in_t DIR_Y [N_DIR] = '{
    16'sd0, 16'sd16384, -16'sd16384, -16'sd32768, 16'sd32767, 16'sd8192,
    -16'sd8192, 16'sd8191, -16'sd8193, 16'sd8193, 16'sd0, 16'sd1,
    -16'sd1, 16'sd100, -16'sd24576, 16'sd24575
  };

  localparam int N_PHASE = 12;
  localparam logic [6:0] SIDES_SET [N_PHASE] = '{
    7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8, 7'd64, 7'd65, 7'd127, 7'd0
  };

  initial begin
    int k;
    coord_in_t x, y;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.dest_x <= '0;
    in_ch.dest_y <= '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    rst_done = 1'b1;
    @(posedge clk);

    for (int p = 0; p < N_PHASE; p++) begin
      // Write sides only with the pipe drained; last phase picks at random.
      cfg_we   <= 1'b1;
      cfg_data <= (p == N_PHASE - 1) ? 7'($urandom_range(3, 127)) : SIDES_SET[p];
      @(posedge clk);
      cfg_we <= 1'b0;

      for (int i = 0; i < N_DIR; i++) send_coord(DIR_X[i], DIR_Y[i]);
      for (int i = 0; i < 130; i++) begin
        k = $urandom_range(0, 9);
        x = rand_coord(k < 2 ? 0 : 1);
        y = rand_coord(k < 2 ? 0 : (k >= 8 ? 2 : 1));
        if (k == 9) y = -y;
        send_coord(x, y);
      end

      // Drop valid and drain before the next register write.
      in_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clk);
      repeat (8) @(posedge clk);
    end

    // Allow for any stray result beyond the pipe latency.
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("[equirect_to_cylinder_coord_map] OK");
    else $display("[equirect_to_cylinder_coord_map] ERROR");
    $finish;
  end
endmodule
